[src/r2fft_pkg.sv]
`default_nettype none
package r2fft_pkg;

    localparam int LOG2_MAX_LENGTH_DEF = 8;
    localparam int ROM_LOG2 = 8;
    localparam int ROM_QTR  = 64;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_READ = 1'b1;

    // config register indexes
    localparam logic [3:0] REG_INVERSE = 4'd0;
    localparam logic [3:0] REG_LOG2    = 4'd1;

    typedef struct packed {
        logic              action;
        logic [7:0]        index;
        logic signed [15:0] real_in;
        logic signed [15:0] imag_in;
        logic              last;
    } cmd_t;

    typedef struct packed {
        logic signed [23:0] real_out;
        logic signed [23:0] imag_out;
    } res_t;

    // queued load or read operation from front to back
    typedef struct packed {
        logic              action;
        logic [7:0]        index;
        logic signed [23:0] re;
        logic signed [23:0] im;
        logic              last;
        logic              inv;
        logic [3:0]        lg;
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REV_RD,
        ST_REV_WR,
        ST_BF_RD,
        ST_BF_MUL,
        ST_BF_WR,
        ST_SC,
        ST_SC_END
    } bk_state_t;

    // quarter-wave sine of 2*pi*k/256 scaled by 32767
    function automatic logic signed [15:0] sine_rom(input logic [6:0] k);
        logic signed [15:0] t [0:64];
        t = '{16'sd0, 16'sd804, 16'sd1608, 16'sd2410, 16'sd3212, 16'sd4011, 16'sd4808,
              16'sd5602, 16'sd6393, 16'sd7179, 16'sd7962, 16'sd8739, 16'sd9512,
              16'sd10278, 16'sd11039, 16'sd11793, 16'sd12539, 16'sd13279, 16'sd14010,
              16'sd14732, 16'sd15446, 16'sd16151, 16'sd16846, 16'sd17530, 16'sd18204,
              16'sd18868, 16'sd19519, 16'sd20159, 16'sd20787, 16'sd21403, 16'sd22005,
              16'sd22594, 16'sd23170, 16'sd23731, 16'sd24279, 16'sd24811, 16'sd25329,
              16'sd25832, 16'sd26319, 16'sd26790, 16'sd27245, 16'sd27683, 16'sd28105,
              16'sd28510, 16'sd28898, 16'sd29268, 16'sd29621, 16'sd29956, 16'sd30273,
              16'sd30571, 16'sd30852, 16'sd31113, 16'sd31356, 16'sd31580, 16'sd31785,
              16'sd31971, 16'sd32137, 16'sd32285, 16'sd32412, 16'sd32521, 16'sd32609,
              16'sd32678, 16'sd32728, 16'sd32757, 16'sd32767};
        if (k > 7'd64)
            return 16'sd32767;
        return t[k];
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [25:0] v);
        if (v > 26'sd8388607)
            return 24'sd8388607;
        if (v < -26'sd8388608)
            return -24'sd8388608;
        return v[23:0];
    endfunction

endpackage
`default_nettype wire

[src/r2fft_front.sv]
`default_nettype none
module r2fft_front
    import r2fft_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire cmd_t       cmd,
    input  wire logic       cfg_we,
    input  wire logic [3:0] cfg_index,
    input  wire logic [3:0] cfg_data,
    input  wire logic       q_full,
    output logic            accept,
    output logic            q_push,
    output op_t             q_data
);
    logic       inv_reg;
    logic [3:0] lg_reg;
    logic [3:0] lg_act;
    logic [7:0] mask;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_reg <= 1'b0;
            lg_reg  <= 4'd8;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_INVERSE)
                inv_reg <= cfg_data[0];
            else if (cfg_index == REG_LOG2)
                lg_reg <= cfg_data;
        end
    end

    // clamp length and mask index
    always_comb
    begin
        lg_act = lg_reg;
        if (lg_act == 4'd0)
            lg_act = 4'd1;
        if (lg_act > 4'd8)
            lg_act = 4'd8;
        mask = 8'((9'd1 << lg_act) - 9'd1);
    end

    assign accept = start && !q_full;
    assign q_push = accept;

    // classify beat into queue op
    always_comb
    begin
        q_data.action = cmd.action;
        q_data.index  = cmd.index & mask;
        q_data.re     = 24'(cmd.real_in);
        q_data.im     = 24'(cmd.imag_in);
        q_data.last   = (cmd.action == ACT_LOAD) && cmd.last;
        q_data.inv    = inv_reg;
        q_data.lg     = lg_act;
    end
endmodule
`default_nettype wire

[src/r2fft_back.sv]
`default_nettype none
module r2fft_back
    import r2fft_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic q_valid,
    input  wire op_t  q_data,
    output logic      q_pop,
    output logic      run,
    output logic      result_valid,
    output res_t      result
);
    bk_state_t  state_reg, state_next;
    logic [47:0] mem [0:255];
    logic [47:0] rd_a_reg, rd_b_reg;
    logic [7:0]  i_reg, i_next;
    logic [3:0]  s_reg, s_next;
    logic [6:0]  k_reg, k_next;
    logic [7:0]  j_reg, j_next;
    logic [3:0]  lg_reg;
    logic        inv_reg;
    logic [7:0]  rev;
    logic [7:0]  addr_a, addr_b;
    logic        we_a, we_b;
    logic [47:0] wd_a, wd_b;
    logic signed [31:0] pr_reg, pi_reg;
    logic signed [15:0] cw, sw, ws;
    logic [7:0]  e;
    logic [7:0]  f;
    logic [7:0]  half;
    logic signed [23:0] br, bi, ar, ai;
    logic signed [40:0] m1, m2;
    logic        rvalid_reg;
    logic [7:0]  nmask;

    assign nmask = 8'((9'd1 << lg_reg) - 9'd1);
    assign half  = 8'(9'd1 << (s_reg - 4'd1));

    // bit reverse of i within lg bits
    always_comb
    begin
        rev = '0;
        for (int b = 0; b < 8; b++)
            if (b < int'(lg_reg))
                rev[int'(lg_reg) - 1 - b] = i_reg[b];
    end

    // twiddle from quarter-wave rom
    always_comb
    begin
        e  = 8'(k_reg << (4'd8 - s_reg));
        f  = 8'(e - 8'd64);
        if (e <= 8'd64)
        begin
            cw = sine_rom(7'(8'd64 - e));
            sw = sine_rom(e[6:0]);
        end
        else
        begin
            cw = -sine_rom(f[6:0]);
            sw = sine_rom(7'(8'd64 - f));
        end
        ws = inv_reg ? sw : -sw;
    end

    assign ar = rd_a_reg[47:24];
    assign ai = rd_a_reg[23:0];
    assign br = rd_b_reg[47:24];
    assign bi = rd_b_reg[23:0];

    // complex multiply, rounded half up
    always_comb
    begin
        m1 = 41'(cw * br) - 41'(ws * bi) + 41'sd16384;
        m2 = 41'(cw * bi) + 41'(ws * br) + 41'sd16384;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (q_valid && q_data.last) state_next = ST_REV_RD;
            ST_REV_RD: state_next = ST_REV_WR;
            ST_REV_WR: state_next = (i_reg == nmask) ? ST_BF_RD : ST_REV_RD;
            ST_BF_RD:  state_next = ST_BF_MUL;
            ST_BF_MUL: state_next = ST_BF_WR;
            ST_BF_WR:
                if ((j_reg + 8'(k_reg) + half) == nmask && s_reg == lg_reg)
                    state_next = inv_reg ? ST_SC : ST_IDLE;
                else
                    state_next = ST_BF_RD;
            ST_SC:     if (i_reg == nmask) state_next = ST_SC_END;
            ST_SC_END: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // counters
    always_comb
    begin
        i_next = i_reg;
        s_next = s_reg;
        k_next = k_reg;
        j_next = j_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                i_next = '0; s_next = 4'd1; k_next = '0; j_next = '0;
            end
            ST_REV_WR: i_next = (i_reg == nmask) ? 8'd0 : i_reg + 8'd1;
            ST_BF_WR:
            begin
                if (8'(k_reg) + 8'd1 < half)
                    k_next = k_reg + 7'd1;
                else
                begin
                    k_next = '0;
                    if (j_reg + (half << 1) <= nmask && (j_reg + (half << 1)) != 8'd0
                        && 9'(j_reg) + 9'(half << 1) <= 9'(nmask))
                        j_next = j_reg + (half << 1);
                    else
                    begin
                        j_next = '0;
                        s_next = s_reg + 4'd1;
                    end
                end
            end
            ST_SC: i_next = i_reg + 8'd1;
            default: ;
        endcase
    end

    // memory port control
    always_comb
    begin
        addr_a = i_reg;
        addr_b = rev;
        we_a = 1'b0; we_b = 1'b0;
        wd_a = '0; wd_b = '0;
        q_pop = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                q_pop  = q_valid;
                addr_a = q_data.index;
                we_a   = q_valid && q_data.action == ACT_LOAD;
                wd_a   = {q_data.re, q_data.im};
            end
            ST_REV_WR:
            begin
                we_a = i_reg < rev; we_b = i_reg < rev;
                wd_a = rd_b_reg; wd_b = rd_a_reg;
            end
            ST_BF_RD, ST_BF_MUL, ST_BF_WR:
            begin
                addr_a = j_reg + 8'(k_reg);
                addr_b = j_reg + 8'(k_reg) + half;
                we_a = state_reg == ST_BF_WR;
                we_b = state_reg == ST_BF_WR;
                wd_a = {sat24(26'(ar) + 26'(pr_reg)), sat24(26'(ai) + 26'(pi_reg))};
                wd_b = {sat24(26'(ar) - 26'(pr_reg)), sat24(26'(ai) - 26'(pi_reg))};
            end
            ST_SC, ST_SC_END:
            begin
                // entry read last cycle is scaled and written back one behind
                addr_a = i_reg;
                addr_b = i_reg - 8'd1;
                we_b = (state_reg == ST_SC_END) || (i_reg != 8'd0);
                wd_b = {ar >>> lg_reg, ai >>> lg_reg};
            end
            default: ;
        endcase
    end

    // memory, two ports
    always_ff @(posedge clk)
    begin
        if (we_a)
            mem[addr_a] <= wd_a;
        if (we_b)
            mem[addr_b] <= wd_b;
        rd_a_reg <= mem[addr_a];
        rd_b_reg <= mem[addr_b];
    end

    // product registers
    always_ff @(posedge clk)
    begin
        pr_reg <= 32'(m1 >>> 15);
        pi_reg <= 32'(m2 >>> 15);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            i_reg <= '0; s_reg <= 4'd1; k_reg <= '0; j_reg <= '0;
            lg_reg <= 4'd8; inv_reg <= 1'b0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg <= i_next; s_reg <= s_next; k_reg <= k_next; j_reg <= j_next;
            if (state_reg == ST_IDLE && q_valid)
            begin
                lg_reg  <= q_data.lg;
                inv_reg <= q_data.inv;
            end
            rvalid_reg <= state_reg == ST_IDLE && q_valid && q_data.action == ACT_READ;
        end
    end

    assign run = state_reg != ST_IDLE;
    assign result_valid = rvalid_reg;
    assign result = {rd_a_reg[47:24], rd_a_reg[23:0]};
endmodule
`default_nettype wire

[src/radix2_complex_fft.sv]
`default_nettype none
// load and read: the queue register, then the result register; one beat a cycle while idle
// a last load starts the work: bit-reverse pass, (N/2)*log2 N butterflies, then a scaling pass
// when inverse; each butterfly reads, multiplies, writes on the two-port sample memory
// busy stays high during a run; results cannot be stalled
// async active-low reset clears control; sample memory is undefined until loaded
module radix2_complex_fft
    import r2fft_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire cmd_t       cmd,
    output logic            busy,
    input  wire logic       cfg_we,
    input  wire logic [3:0] cfg_index,
    input  wire logic [3:0] cfg_data,
    output logic            result_valid,
    output res_t            result
);
    logic accept, push, pop, run, full_reg;
    op_t  in_op, q_reg;

    r2fft_front u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .cmd(cmd),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .q_full(busy), .accept(accept), .q_push(push), .q_data(in_op)
    );

    // one-entry queue between front and back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            full_reg <= 1'b0;
        else
            full_reg <= push || (full_reg && !pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg <= in_op;
    end

    assign busy = run || (full_reg && q_reg.last);

    r2fft_back u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(full_reg), .q_data(q_reg),
        .q_pop(pop), .run(run), .result_valid(result_valid), .result(result)
    );
endmodule
`default_nettype wire

[tb/sv/radix2_complex_fft_tb.sv]
`default_nettype none
module radix2_complex_fft_tb;
    import r2fft_pkg::*;

    localparam int         STORE_DEPTH = 256;
    localparam int         QTR         = 64;

    logic       clk;
    logic       rst_n;
    logic       start;
    cmd_t       cmd;
    logic       busy;
    logic       cfg_we;
    logic [3:0] cfg_index;
    logic [3:0] cfg_data;
    logic       result_valid;
    res_t       result;

    radix2_complex_fft u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .cmd          (cmd),
        .busy         (busy),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result       (result)
    );

    // predictor state: bin store, registers, twiddle table
    longint bin_re [STORE_DEPTH];
    longint bin_im [STORE_DEPTH];
    logic   inv_now;
    logic [3:0] lg_now;
    longint twiddle_sin [QTR + 1];

    cmd_t   pending_cmds [$];
    res_t   expected_bins [$];
    int     errors;
    int     n_loads;
    int     n_reads;
    int     n_runs;
    int     n_checked;
    int     gap_left;

    // generator-side length in use
    int     gen_lg;

    // sine of 2*pi*k/256 from a 13-term taylor series in q30
    function automatic longint taylor_sine(input int k);
        longint unsigned theta;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        longint          r;
        theta = (64'd2 * 64'd3373259426 * longint'(k)) >> 8;
        x2    = (theta * theta) >> 30;
        term  = theta;
        sum   = longint'(theta);
        for (int n = 1; n <= 12; n++)
        begin
            term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        r = (sum * 32767 + (64'sd1 <<< 29)) >>> 30;
        if (r > 32767)
            r = 32767;
        return r;
    endfunction

    function automatic int eff_log2(input logic [3:0] lg);
        if (lg < 1)
            return 1;
        if (lg > 8)
            return 8;
        return lg;
    endfunction

    function automatic longint clip24(input longint v);
        if (v > 8388607)
            return 8388607;
        if (v < -8388608)
            return -8388608;
        return v;
    endfunction

    // in-place transform over the active length
    task automatic run_fft();
        int     lg;
        int     n;
        int     r;
        int     e;
        int     f;
        int     p;
        int     q;
        int     half;
        longint tmp;
        longint c;
        longint sn;
        longint ws;
        longint tr;
        longint ti;
        longint ar;
        longint ai;
        lg = eff_log2(lg_now);
        n  = 1 << lg;
        for (int i = 0; i < n; i++)
        begin
            r = 0;
            for (int b = 0; b < lg; b++)
                r |= ((i >> b) & 1) << (lg - 1 - b);
            if (i < r)
            begin
                tmp = bin_re[i]; bin_re[i] = bin_re[r]; bin_re[r] = tmp;
                tmp = bin_im[i]; bin_im[i] = bin_im[r]; bin_im[r] = tmp;
            end
        end
        for (int s = 1; s <= lg; s++)
        begin
            half = 1 << (s - 1);
            for (int j = 0; j < n; j += 2 * half)
            begin
                for (int k = 0; k < half; k++)
                begin
                    e = k << (8 - s);
                    if (e <= QTR)
                    begin
                        c  = twiddle_sin[QTR - e];
                        sn = twiddle_sin[e];
                    end
                    else
                    begin
                        f = (e - QTR) & (2 * QTR - 1);
                        if (f > QTR)
                            f = QTR;
                        c  = -twiddle_sin[f];
                        sn = twiddle_sin[QTR - f];
                    end
                    ws = inv_now ? sn : -sn;
                    p  = j + k;
                    q  = j + k + half;
                    ar = bin_re[p];
                    ai = bin_im[p];
                    tr = (c * bin_re[q] - ws * bin_im[q] + 16384) >>> 15;
                    ti = (c * bin_im[q] + ws * bin_re[q] + 16384) >>> 15;
                    bin_re[p] = clip24(ar + tr);
                    bin_im[p] = clip24(ai + ti);
                    bin_re[q] = clip24(ar - tr);
                    bin_im[q] = clip24(ai - ti);
                end
            end
        end
        if (inv_now)
        begin
            for (int i = 0; i < n; i++)
            begin
                bin_re[i] = bin_re[i] >>> lg;
                bin_im[i] = bin_im[i] >>> lg;
            end
        end
    endtask

    // update the predicted store for one accepted beat
    task automatic predict_beat(input cmd_t c);
        int   idx;
        res_t exp_bin;
        idx = int'(c.index) & ((1 << eff_log2(lg_now)) - 1);
        if (c.action == ACT_LOAD)
        begin
            n_loads++;
            bin_re[idx] = longint'(c.real_in);
            bin_im[idx] = longint'(c.imag_in);
            if (c.last)
            begin
                n_runs++;
                run_fft();
            end
        end
        else
        begin
            n_reads++;
            exp_bin.real_out = bin_re[idx][23:0];
            exp_bin.imag_out = bin_im[idx][23:0];
            expected_bins.push_back(exp_bin);
        end
    endtask

    // stimulus generation helpers
    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return ($urandom_range(0, 1) != 0) ? 16'h0000 : 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic push_load(input int idx, input logic [15:0] re, input logic [15:0] im,
                             input logic lst);
        cmd_t c;
        c.action  = ACT_LOAD;
        c.index   = idx[7:0];
        c.real_in = re;
        c.imag_in = im;
        c.last    = lst;
        pending_cmds.push_back(c);
    endtask

    task automatic push_read(input int idx);
        cmd_t c;
        c.action  = ACT_READ;
        c.index   = idx[7:0];
        c.real_in = 16'($urandom);
        c.imag_in = 16'($urandom);
        c.last    = 1'($urandom_range(0, 1));
        pending_cmds.push_back(c);
    endtask

    // one well-formed frame: all bins in random order, last on the final one, then reads, then maybe noise
    task automatic push_frame(input int reads);
        int n;
        int lg;
        int order [$];
        int j;
        int tmp;
        int idx;
        lg = eff_log2(4'(gen_lg));
        n  = 1 << lg;
        for (int i = 0; i < n; i++)
            order.push_back(i);
        for (int i = n - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            tmp = order[i]; order[i] = order[j]; order[j] = tmp;
        end
        for (int i = 0; i < n; i++)
        begin
            // upper index bits are random to exercise the wrap
            idx = (order[i] | ($urandom << lg)) & 8'hff;
            push_load(idx, pick_sample(), pick_sample(), i == n - 1);
        end
        for (int i = 0; i < reads; i++)
            push_read($urandom_range(0, 255));
        // noise: stray loads and reads at random indexes
        if ($urandom_range(0, 2) == 0)
        begin
            for (int i = 0; i < $urandom_range(1, 4); i++)
            begin
                if ($urandom_range(0, 1) != 0)
                    push_load($urandom_range(0, 255), pick_sample(), pick_sample(), 1'b0);
                else
                    push_read($urandom_range(0, 255));
            end
        end
    endtask

    task automatic wait_idle();
        while (pending_cmds.size() != 0 || expected_bins.size() != 0 || busy || start)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [3:0] idx, input logic [3:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        if (idx == REG_INVERSE)
            inv_now = data[0];
        else
            lg_now = data;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_mode(input logic inv, input logic [3:0] lg);
        wait_idle();
        write_reg(REG_INVERSE, {3'($urandom), inv});
        write_reg(REG_LOG2, lg);
        gen_lg = lg;
    endtask

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // command driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start    <= 1'b0;
            cmd      <= '0;
            gap_left <= 0;
        end
        else
        begin : drive
            logic next_start;
            int   gap;
            gap = gap_left;
            if (start && !busy)
            begin
                predict_beat(cmd);
                void'(pending_cmds.pop_front());
                case ($urandom_range(0, 19))
                    0:       gap = $urandom_range(10, 40);
                    1, 2, 3, 4, 5: gap = $urandom_range(1, 3);
                    default: gap = 0;
                endcase
            end
            next_start = 1'b0;
            if (gap > 0)
                gap--;
            else if (pending_cmds.size() != 0)
            begin
                next_start = 1'b1;
                cmd <= pending_cmds[0];
            end
            start    <= next_start;
            gap_left <= gap;
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (expected_bins.size() == 0)
            begin
                $display("%0t: unexpected bin re=%0d im=%0d", $time,
                         result.real_out, result.imag_out);
                errors++;
            end
            else
            begin : compare
                res_t exp_bin;
                exp_bin = expected_bins.pop_front();
                n_checked++;
                if (result.real_out !== exp_bin.real_out)
                begin
                    $display("%0t: real mismatch expected %0d actual %0d", $time,
                             exp_bin.real_out, result.real_out);
                    errors++;
                end
                if (result.imag_out !== exp_bin.imag_out)
                begin
                    $display("%0t: imag mismatch expected %0d actual %0d", $time,
                             exp_bin.imag_out, result.imag_out);
                    errors++;
                end
            end
        end
    end

    // main sequence
    initial
    begin
        int lg;
        errors    = 0;
        n_loads   = 0;
        n_reads   = 0;
        n_runs    = 0;
        n_checked = 0;
        inv_now   = 1'b0;
        lg_now    = 4'd8;
        gen_lg    = 8;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        for (int k = 0; k <= QTR; k++)
            twiddle_sin[k] = taylor_sine(k);
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: zero length acts as two, extremes, wrap, last on read
        set_mode(1'b0, 4'd0);
        push_load(0, 16'h7fff, 16'h8000, 1'b0);
        push_load(255, 16'h8000, 16'h7fff, 1'b1);
        push_read(0);
        push_read(1);
        push_read(3);
        set_mode(1'b1, 4'd1);
        push_load(2, 16'h7fff, 16'h7fff, 1'b0);
        push_load(1, 16'h8000, 16'h8000, 1'b1);
        push_read(0);
        push_read(255);
        set_mode(1'b0, 4'd3);
        push_frame(8);

        // random phases
        while (n_loads + n_reads + pending_cmds.size() < 140)
        begin
            case ($urandom_range(0, 9))
                0:       lg = $urandom_range(5, 6);
                1:       lg = 0;
                default: lg = $urandom_range(1, 5);
            endcase
            set_mode(1'($urandom_range(0, 1)), 4'(lg));
            repeat ($urandom_range(1, 3))
                push_frame($urandom_range(2, 12));
        end
        // full length, both directions, with an out-of-range length code
        set_mode(1'b1, 4'd15);
        push_frame(24);
        set_mode(1'b0, 4'd8);
        push_frame(24);

        wait_idle();
        repeat (20) @(posedge clk);
        $display("covered %0d loads, %0d reads, %0d transforms, %0d bins checked",
                 n_loads, n_reads, n_runs, n_checked);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // watchdog
    initial
    begin
        #40000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
`default_nettype wire
